@@ src/tet_refinement_cell_emitter_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Tetrahedral refinement cell emitter: assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef TET_REFINEMENT_CELL_EMITTER_UNIT_DEFINES_SVH
`define TET_REFINEMENT_CELL_EMITTER_UNIT_DEFINES_SVH

// same-cycle implication
`define TRE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TRE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/tre_pkg.sv @@
// ----------------------------------------------------------------------------
// tre_pkg
// Shared types, codes and tables of the tetrahedral refinement cell emitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tre_pkg;

  localparam int MAX_DIVISIONS = 15;
  localparam int COORD_BITS    = 24;
  localparam int IDX_W         = 4;
  localparam int ADDR_W        = 3 * IDX_W;
  localparam int STORE_DEPTH   = 1 << ADDR_W;
  localparam int VID_W         = 32;
  localparam int XYZ_W         = 3 * COORD_BITS;
  localparam int DIST_W        = 2 * COORD_BITS + 2;

  localparam logic [1:0] FUNC_LOAD    = 2'd0;
  localparam logic [1:0] FUNC_STEP    = 2'd1;
  localparam logic [1:0] FUNC_RESTART = 2'd2;

  localparam logic [2:0] KIND_UP = 3'd0;
  localparam logic [2:0] KIND_DN = 3'd1;
  localparam logic [2:0] KIND_AF = 3'd2;
  localparam logic [2:0] KIND_BD = 3'd3;
  localparam logic [2:0] KIND_CE = 3'd4;

  localparam logic [1:0] PH_UP   = 2'd0;
  localparam logic [1:0] PH_DN   = 2'd1;
  localparam logic [1:0] PH_OCTA = 2'd2;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [XYZ_W-1:0]  xyz_t;

  function automatic addr_t pt_addr(input logic [IDX_W-1:0] i, input logic [IDX_W-1:0] j,
                                    input logic [IDX_W-1:0] k);
    return {k, j, i};
  endfunction

  // Store address of point idx of the current cell. Octahedron points A..F are 0..5.
  function automatic addr_t cell_point(input logic [1:0] ph, input logic [2:0] idx,
                                       input logic [IDX_W-1:0] i, input logic [IDX_W-1:0] j,
                                       input logic [IDX_W-1:0] k);
    logic [IDX_W-1:0] ip, im, jp, kp;
    addr_t a;
    ip = i + 1'b1;
    im = i - 1'b1;
    jp = j + 1'b1;
    kp = k + 1'b1;
    a  = pt_addr(i, j, k);
    case (ph)
      PH_UP: begin
        case (idx)
          3'd1:    a = pt_addr(ip, j, k);
          3'd2:    a = pt_addr(i, jp, k);
          3'd3:    a = pt_addr(i, j, kp);
          default: a = pt_addr(i, j, k);
        endcase
      end
      PH_DN: begin
        case (idx)
          3'd1:    a = pt_addr(im, jp, kp);
          3'd2:    a = pt_addr(i, jp, kp);
          3'd3:    a = pt_addr(i, jp, k);
          default: a = pt_addr(i, j, kp);
        endcase
      end
      default: begin
        case (idx)
          3'd1:    a = pt_addr(i, jp, k);
          3'd2:    a = pt_addr(im, jp, k);
          3'd3:    a = pt_addr(im, j, kp);
          3'd4:    a = pt_addr(i, j, kp);
          3'd5:    a = pt_addr(im, jp, kp);
          default: a = pt_addr(i, j, k);
        endcase
      end
    endcase
    return a;
  endfunction

  // Which gathered point feeds vertex t of result m.
  function automatic logic [2:0] res_point(input logic [2:0] kind, input logic [1:0] m,
                                           input logic [1:0] t);
    logic [2:0] r0, r1, r2, r3, p, q, a, b;
    logic [1:0] mn;
    r0 = 3'd1; r1 = 3'd2; r2 = 3'd3; r3 = 3'd4; p = 3'd0; q = 3'd5;
    case (kind)
      KIND_BD: begin
        r0 = 3'd2; r1 = 3'd0; r2 = 3'd4; r3 = 3'd5; p = 3'd1; q = 3'd3;
      end
      KIND_CE: begin
        r0 = 3'd0; r1 = 3'd1; r2 = 3'd5; r3 = 3'd3; p = 3'd2; q = 3'd4;
      end
      default: ;
    endcase
    mn = m + 1'b1;
    case (m)
      2'd0:    a = r0;
      2'd1:    a = r1;
      2'd2:    a = r2;
      default: a = r3;
    endcase
    case (mn)
      2'd0:    b = r0;
      2'd1:    b = r1;
      2'd2:    b = r2;
      default: b = r3;
    endcase
    if (kind == KIND_UP || kind == KIND_DN) begin
      return {1'b0, t};
    end
    case (t)
      2'd0:    return a;
      2'd1:    return b;
      2'd2:    return p;
      default: return q;
    endcase
  endfunction

endpackage

@@ src/tre_store.sv @@
// ----------------------------------------------------------------------------
// tre_store
// Lattice point store: vertex ids and coordinates, one write and one read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tre_store import tre_pkg::*; (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  addr_t            wr_addr_i,
  input  logic [VID_W-1:0] wr_vid_i,
  input  xyz_t             wr_xyz_i,
  input  logic             rd_en_i,
  input  addr_t            rd_addr_i,
  output logic [VID_W-1:0] rd_vid_o,
  output xyz_t             rd_xyz_o
);

  logic [VID_W-1:0] vid_mem [STORE_DEPTH];
  xyz_t             xyz_mem [STORE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      vid_mem[wr_addr_i] <= wr_vid_i;
      xyz_mem[wr_addr_i] <= wr_xyz_i;
    end
    if (rd_en_i) begin
      rd_vid_o <= vid_mem[rd_addr_i];
      rd_xyz_o <= xyz_mem[rd_addr_i];
    end
  end

endmodule

@@ src/tre_dist.sv @@
// ----------------------------------------------------------------------------
// tre_dist
// Exact squared distance of two points, one axis per cycle through one multiplier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tre_dist import tre_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  xyz_t              a_i,
  input  xyz_t              b_i,
  output logic              done_o,
  output logic [DIST_W-1:0] sum_o
);

  xyz_t                          a_q, b_q;
  logic                          busy_q, dv_q, sv_q, done_q;
  logic [1:0]                    issue_q, acc_n_q;
  logic signed [COORD_BITS:0]    diff_q, diff_d;
  logic signed [2*COORD_BITS+1:0] sq_q;
  logic [DIST_W-1:0]             acc_q;
  logic signed [COORD_BITS-1:0]  ca, cb;

  always_comb begin
    case (issue_q)
      2'd0: begin
        ca = a_q[3*COORD_BITS-1:2*COORD_BITS];
        cb = b_q[3*COORD_BITS-1:2*COORD_BITS];
      end
      2'd1: begin
        ca = a_q[2*COORD_BITS-1:COORD_BITS];
        cb = b_q[2*COORD_BITS-1:COORD_BITS];
      end
      default: begin
        ca = a_q[COORD_BITS-1:0];
        cb = b_q[COORD_BITS-1:0];
      end
    endcase
    diff_d = {ca[COORD_BITS-1], ca} - {cb[COORD_BITS-1], cb};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      dv_q    <= 1'b0;
      sv_q    <= 1'b0;
      done_q  <= 1'b0;
      issue_q <= 2'd0;
      acc_n_q <= 2'd0;
    end else begin
      sv_q   <= dv_q;
      sq_q   <= diff_q * diff_q;
      dv_q   <= !start_i && busy_q && issue_q != 2'd3;
      done_q <= !start_i && sv_q && acc_n_q == 2'd2;
      if (start_i) begin
        a_q     <= a_i;
        b_q     <= b_i;
        busy_q  <= 1'b1;
        issue_q <= 2'd0;
        acc_n_q <= 2'd0;
        acc_q   <= '0;
      end else begin
        if (busy_q && issue_q != 2'd3) begin
          diff_q  <= diff_d;
          issue_q <= issue_q + 2'd1;
        end
        if (sv_q) begin
          acc_q   <= acc_q + DIST_W'(unsigned'(sq_q));
          acc_n_q <= acc_n_q + 2'd1;
          if (acc_n_q == 2'd2) begin
            busy_q <= 1'b0;
          end
        end
      end
    end
  end

  assign done_o = done_q;
  assign sum_o  = acc_q;

endmodule

@@ src/tet_refinement_cell_emitter_unit.sv @@
// ----------------------------------------------------------------------------
// tet_refinement_cell_emitter_unit
// Uniform tetrahedral refinement: point store and sub-cell enumeration.
// ----------------------------------------------------------------------------
//  channel | dir | handshake             | payload
//  in      | in  | in_valid_i/in_ready_o | func, pt_i/j/k, vertex_id, coord_x/y/z
//  out     | out | out_valid_o/out_ready_i | tet_v0..3, cell_kind, last/done flags
//  cfg     | in  | cfg_valid_i/cfg_ready_o | cfg_data_i (num_divisions)
//
// Load and restart complete on acceptance and leave the block idle. A step walks
// the position one seek step per cycle, reads 4 (tet) or 6 (octahedron) store
// entries through the single read port, runs three distance passes for an
// octahedron, then emits 1 or 4 items; a step on a finished enumeration emits
// nothing. No new input is taken until the step's last item is loaded for output.
// Reset clears the position and control registers only; the store is not cleared.
// Output stalls hold the block in the emit state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "tet_refinement_cell_emitter_unit_defines.svh"

module tet_refinement_cell_emitter_unit import tre_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   func_i,
  input  logic [IDX_W-1:0]             pt_i_i,
  input  logic [IDX_W-1:0]             pt_j_i,
  input  logic [IDX_W-1:0]             pt_k_i,
  input  logic [VID_W-1:0]             vertex_id_i,
  input  logic signed [COORD_BITS-1:0] coord_x_i,
  input  logic signed [COORD_BITS-1:0] coord_y_i,
  input  logic signed [COORD_BITS-1:0] coord_z_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [VID_W-1:0]             tet_v0_o,
  output logic [VID_W-1:0]             tet_v1_o,
  output logic [VID_W-1:0]             tet_v2_o,
  output logic [VID_W-1:0]             tet_v3_o,
  output logic [2:0]                   cell_kind_o,
  output logic                         last_of_group_o,
  output logic                         enumeration_done_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [IDX_W-1:0]             cfg_data_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_SEEK, S_READ, S_RWAIT, S_DSTART, S_DWAIT, S_CHOOSE, S_ADV, S_EMIT
  } state_e;

  state_e state_q;

  logic [IDX_W-1:0] ndiv_q, n;
  logic [IDX_W-1:0] lv_q, row_q, col_q, k;
  logic [1:0]       ph_q;
  logic             fin_q, post_q, done_flag_q;
  logic [2:0]       rc_q, cap_idx_q;
  logic             cap_v_q;
  logic [VID_W-1:0] vid_q [6];
  xyz_t             xyz_q [6];
  logic [DIST_W-1:0] d_q [3];
  logic [1:0]       pc_q, emit_cnt_q;
  logic [2:0]       kind_q, grp_cnt_q;

  logic             out_valid_q, out_last_q, out_done_q;
  logic [VID_W-1:0] out_v0_q, out_v1_q, out_v2_q, out_v3_q;
  logic [2:0]       out_kind_q;

  logic             in_acc, octa, emit_last, emit_load;
  logic             rd_en, dist_done;
  addr_t            rd_addr;
  logic [VID_W-1:0] rd_vid;
  xyz_t             rd_xyz, dist_a, dist_b;
  logic [DIST_W-1:0] dist_sum;
  logic [2:0]       pa, pb;

  // seek step
  logic             sk_stop, sk_fin;
  logic [IDX_W-1:0] sk_lv, sk_row, sk_col;
  logic [1:0]       sk_ph;
  logic signed [IDX_W+1:0] lvs, js, is, jmax, imin, imax;

  assign n  = (ndiv_q > IDX_W'(MAX_DIVISIONS)) ? IDX_W'(MAX_DIVISIONS) : ndiv_q;
  assign k  = n - lv_q;
  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && in_ready_o;
  assign octa        = (ph_q == PH_OCTA);

  always_comb begin
    lvs = signed'({2'b00, lv_q});
    js  = signed'({2'b00, row_q});
    is  = signed'({2'b00, col_q});
    case (ph_q)
      PH_UP: begin
        jmax = lvs - 6'sd1; imin = 6'sd0; imax = lvs - js - 6'sd1;
      end
      PH_DN: begin
        jmax = lvs - 6'sd3; imin = 6'sd1; imax = lvs - js - 6'sd2;
      end
      PH_OCTA: begin
        jmax = lvs - 6'sd2; imin = 6'sd1; imax = lvs - js - 6'sd1;
      end
      default: begin
        jmax = -6'sd1; imin = 6'sd0; imax = -6'sd1;
      end
    endcase
    sk_stop = 1'b0;
    sk_fin  = fin_q;
    sk_lv   = lv_q;
    sk_ph   = ph_q;
    sk_row  = row_q;
    sk_col  = col_q;
    if (fin_q) begin
      sk_stop = 1'b1;
    end else if (lv_q == '0 || lv_q > n) begin
      sk_stop = 1'b1;
      sk_fin  = 1'b1;
    end else if (js > jmax) begin
      sk_row = '0;
      sk_col = '0;
      if (ph_q >= PH_OCTA) begin
        if (lv_q >= n) begin
          sk_stop = 1'b1;
          sk_fin  = 1'b1;
        end else begin
          sk_lv = lv_q + 1'b1;
          sk_ph = PH_UP;
        end
      end else begin
        sk_ph = ph_q + 2'd1;
      end
    end else if (is < imin) begin
      sk_col = imin[IDX_W-1:0];
    end else if (is > imax) begin
      sk_row = row_q + 1'b1;
      sk_col = '0;
    end else begin
      sk_stop = 1'b1;
    end
  end

  assign rd_en   = (state_q == S_READ);
  assign rd_addr = cell_point(ph_q, rc_q, col_q, row_q, k);

  tre_store u_store (
    .clk_i     (clk_i),
    .wr_en_i   (in_acc && func_i == FUNC_LOAD),
    .wr_addr_i (pt_addr(pt_i_i, pt_j_i, pt_k_i)),
    .wr_vid_i  (vertex_id_i),
    .wr_xyz_i  ({coord_x_i, coord_y_i, coord_z_i}),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_vid_o  (rd_vid),
    .rd_xyz_o  (rd_xyz)
  );

  // diagonal pairs: AF, BD, CE
  always_comb begin
    case (pc_q)
      2'd0:    begin pa = 3'd0; pb = 3'd5; end
      2'd1:    begin pa = 3'd1; pb = 3'd3; end
      default: begin pa = 3'd2; pb = 3'd4; end
    endcase
  end
  assign dist_a = xyz_q[pa];
  assign dist_b = xyz_q[pb];

  tre_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_DSTART),
    .a_i     (dist_a),
    .b_i     (dist_b),
    .done_o  (dist_done),
    .sum_o   (dist_sum)
  );

  assign emit_last = ({1'b0, emit_cnt_q} == grp_cnt_q - 3'd1);
  assign emit_load = (state_q == S_EMIT) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ndiv_q      <= IDX_W'(1);
      lv_q        <= IDX_W'(1);
      ph_q        <= PH_UP;
      row_q       <= '0;
      col_q       <= '0;
      fin_q       <= 1'b0;
      post_q      <= 1'b0;
      done_flag_q <= 1'b0;
      rc_q        <= '0;
      cap_v_q     <= 1'b0;
      pc_q        <= '0;
      emit_cnt_q  <= '0;
      grp_cnt_q   <= 3'd1;
      kind_q      <= KIND_UP;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        ndiv_q <= cfg_data_i;
      end
      if (out_ready_i && !emit_load) begin
        out_valid_q <= 1'b0;
      end
      cap_v_q   <= rd_en;
      cap_idx_q <= rc_q;
      if (cap_v_q) begin
        vid_q[cap_idx_q] <= rd_vid;
        xyz_q[cap_idx_q] <= rd_xyz;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            case (func_i)
              FUNC_STEP: begin
                post_q  <= 1'b0;
                state_q <= S_SEEK;
              end
              FUNC_RESTART: begin
                lv_q  <= IDX_W'(1);
                ph_q  <= PH_UP;
                row_q <= '0;
                col_q <= '0;
                fin_q <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        S_SEEK: begin
          fin_q <= sk_fin;
          lv_q  <= sk_lv;
          ph_q  <= sk_ph;
          row_q <= sk_row;
          col_q <= sk_col;
          if (sk_stop) begin
            if (post_q) begin
              done_flag_q <= sk_fin;
              emit_cnt_q  <= '0;
              state_q     <= S_EMIT;
            end else if (sk_fin) begin
              state_q <= S_IDLE;
            end else begin
              rc_q    <= '0;
              state_q <= S_READ;
            end
          end
        end
        S_READ: begin
          rc_q <= rc_q + 3'd1;
          if (rc_q == (octa ? 3'd5 : 3'd3)) begin
            state_q <= S_RWAIT;
          end
        end
        S_RWAIT: begin
          if (octa) begin
            pc_q    <= '0;
            state_q <= S_DSTART;
          end else begin
            kind_q    <= (ph_q == PH_UP) ? KIND_UP : KIND_DN;
            grp_cnt_q <= 3'd1;
            state_q   <= S_ADV;
          end
        end
        S_DSTART: begin
          state_q <= S_DWAIT;
        end
        S_DWAIT: begin
          if (dist_done) begin
            d_q[pc_q] <= dist_sum;
            if (pc_q == 2'd2) begin
              state_q <= S_CHOOSE;
            end else begin
              pc_q    <= pc_q + 2'd1;
              state_q <= S_DSTART;
            end
          end
        end
        S_CHOOSE: begin
          if (d_q[0] <= d_q[1] && d_q[0] <= d_q[2]) begin
            kind_q <= KIND_AF;
          end else if (d_q[1] <= d_q[2]) begin
            kind_q <= KIND_BD;
          end else begin
            kind_q <= KIND_CE;
          end
          grp_cnt_q <= 3'd4;
          state_q   <= S_ADV;
        end
        S_ADV: begin
          col_q   <= col_q + 1'b1;
          post_q  <= 1'b1;
          state_q <= S_SEEK;
        end
        S_EMIT: begin
          if (emit_load) begin
            out_valid_q <= 1'b1;
            out_v0_q    <= vid_q[res_point(kind_q, emit_cnt_q, 2'd0)];
            out_v1_q    <= vid_q[res_point(kind_q, emit_cnt_q, 2'd1)];
            out_v2_q    <= vid_q[res_point(kind_q, emit_cnt_q, 2'd2)];
            out_v3_q    <= vid_q[res_point(kind_q, emit_cnt_q, 2'd3)];
            out_kind_q  <= kind_q;
            out_last_q  <= emit_last;
            out_done_q  <= emit_last && done_flag_q;
            emit_cnt_q  <= emit_cnt_q + 2'd1;
            if (emit_last) begin
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o        = out_valid_q;
  assign tet_v0_o           = out_v0_q;
  assign tet_v1_o           = out_v1_q;
  assign tet_v2_o           = out_v2_q;
  assign tet_v3_o           = out_v3_q;
  assign cell_kind_o        = out_kind_q;
  assign last_of_group_o    = out_last_q;
  assign enumeration_done_o = out_done_q;

  `TRE_ASSERT_NEXT(a_step_busy, in_valid_i && in_ready_o && func_i == FUNC_STEP, !in_ready_o, "step not started")
  `TRE_ASSERT_NOW(a_done_is_last, out_valid_o && enumeration_done_o, last_of_group_o, "done not on last")
  `TRE_ASSERT_NOW(a_emit_bound, state_q == S_EMIT, 3'(emit_cnt_q) < grp_cnt_q, "emit count overrun")

endmodule
